/* rtl/trwm_pkg.sv */
// Shared types and constants for the transfer rate window monitor.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
package trwm_pkg;

  localparam int unsigned LOG_DEPTH_DEFAULT = 64;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned BYTES_W   = 32;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned TICKS_W   = 32;
  localparam int unsigned COUNT_W   = 64;
  localparam int unsigned THRESH_W  = 16;
  localparam int unsigned SUM_W     = 37;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // One mebibyte is 1024 * 1024 bytes.
  localparam int unsigned MIB_SHIFT = 20;

  // Sixty seconds at a thousand ticks per second.
  localparam logic [TICKS_W-1:0] WINDOW_TICKS_RESET = TICKS_W'(60 * 1000);

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_RECORD = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 1'd0,
    CFG_WINDOW    = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTES_W-1:0]  byte_count;
    logic [TAG_W-1:0]    device_tag;
  } item_t;

  typedef struct packed {
    logic [THRESH_W-1:0] threshold_mib;
    logic [TICKS_W-1:0]  window_ticks;
  } cfg_t;

endpackage

/* rtl/trwm_cfg_regs.sv */
// Configuration registers of the transfer rate window monitor.
// Depends on trwm_pkg for the register indexes and the cfg_t bundle.
module trwm_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [trwm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [trwm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output trwm_pkg::cfg_t                      cfg_o
);

  logic [trwm_pkg::THRESH_W-1:0] threshold_q, threshold_d;
  logic [trwm_pkg::TICKS_W-1:0]  window_q, window_d;

  always_comb begin
    threshold_d = threshold_q;
    window_d    = window_q;
    if (cfg_we_i) begin
      case (trwm_pkg::cfg_idx_e'(cfg_idx_i))
        trwm_pkg::CFG_THRESHOLD: threshold_d = cfg_data_i[trwm_pkg::THRESH_W-1:0];
        trwm_pkg::CFG_WINDOW:    window_d    = cfg_data_i[trwm_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      window_q    <= trwm_pkg::WINDOW_TICKS_RESET;
    end else begin
      threshold_q <= threshold_d;
      window_q    <= window_d;
    end
  end

  assign cfg_o.threshold_mib = threshold_q;
  assign cfg_o.window_ticks  = window_q;

endmodule

/* rtl/trwm_in_reg.sv */
// Input register of the transfer rate window monitor: holds one word until the core takes it.
// Depends on trwm_pkg for the item_t bundle.
module trwm_in_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  trwm_pkg::item_t       item_i,
  output logic                  item_valid_o,
  output trwm_pkg::item_t       item_o,
  input  logic                  take_i
);

  logic            valid_q;
  trwm_pkg::item_t item_q;

  // The register frees up in the same cycle the core takes its word.
  assign in_stall_o = valid_q && !take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* rtl/trwm_core.sv */
// Monitor state, per-word update logic and result register.
// Depends on trwm_pkg for action codes, widths and the item_t and cfg_t bundles.
module trwm_core #(
  parameter  int unsigned LOG_DEPTH = trwm_pkg::LOG_DEPTH_DEFAULT,
  localparam int unsigned SlotW     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1,
  localparam int unsigned FillW     = $clog2(LOG_DEPTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  trwm_pkg::cfg_t                     cfg_i,
  input  logic                               item_valid_i,
  input  trwm_pkg::item_t                    item_i,
  output logic                               take_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [trwm_pkg::COUNT_W-1:0]       event_id_o,
  output logic [SlotW-1:0]                   slot_index_o,
  output logic [FillW-1:0]                   fill_count_o,
  output logic [trwm_pkg::TICKS_W-1:0]       event_time_o,
  output logic [trwm_pkg::TAG_W-1:0]         logged_device_o,
  output logic                               alert_o,
  output logic [trwm_pkg::SUM_W-1:0]         window_sum_o,
  output logic [trwm_pkg::COUNT_W-1:0]       transfers_total_o,
  output logic [trwm_pkg::COUNT_W-1:0]       bytes_total_o,
  output logic [trwm_pkg::COUNT_W-1:0]       alerts_total_o
);

  localparam int unsigned SumW   = trwm_pkg::SUM_W;
  localparam int unsigned CountW = trwm_pkg::COUNT_W;
  localparam int unsigned TicksW = trwm_pkg::TICKS_W;

  logic [TicksW-1:0] now_q, now_d;
  logic [CountW-1:0] transfers_q, transfers_d;
  logic [CountW-1:0] bytes_q, bytes_d;
  logic [CountW-1:0] alerts_q, alerts_d;
  logic [CountW-1:0] seq_q, seq_d;
  logic [TicksW-1:0] wstart_q, wstart_d;
  logic [SumW-1:0]   wsum_q, wsum_d;
  logic [SlotW-1:0]  cursor_q, cursor_d;
  logic [FillW-1:0]  fill_q, fill_d;

  logic              is_record;
  logic              result_free;
  logic [TicksW-1:0] remain;
  logic              expired;
  logic [SumW-1:0]   sum_base;
  logic [SumW:0]     sum_raw;
  logic [SumW-1:0]   sum;
  logic [SumW-1:0]   limit;
  logic              alert;

  logic              out_valid_q;

  assign is_record   = trwm_pkg::action_e'(item_i.action) == trwm_pkg::ACT_RECORD;
  assign result_free = !out_valid_q || !out_stall_i;
  assign take_o      = item_valid_i && (!is_record || result_free);

  // The window has run out once start + length - now goes negative as a 32-bit value.
  assign remain   = wstart_q + cfg_i.window_ticks - now_q;
  assign expired  = remain[TicksW-1];
  assign sum_base = expired ? '0 : wsum_q;
  assign sum_raw  = (SumW+1)'(sum_base) + (SumW+1)'(item_i.byte_count);
  assign sum      = sum_raw[SumW] ? '1 : sum_raw[SumW-1:0];
  assign limit    = SumW'({cfg_i.threshold_mib, {trwm_pkg::MIB_SHIFT{1'b0}}});
  assign alert    = (cfg_i.threshold_mib != '0) && (sum >= limit);

  always_comb begin
    now_d       = now_q;
    transfers_d = transfers_q;
    bytes_d     = bytes_q;
    alerts_d    = alerts_q;
    seq_d       = seq_q;
    wstart_d    = wstart_q;
    wsum_d      = wsum_q;
    cursor_d    = cursor_q;
    fill_d      = fill_q;
    case (trwm_pkg::action_e'(item_i.action))
      trwm_pkg::ACT_TICK: begin
        now_d = now_q + TicksW'(1);
      end
      trwm_pkg::ACT_RECORD: begin
        transfers_d = transfers_q + CountW'(1);
        bytes_d     = bytes_q + CountW'(item_i.byte_count);
        seq_d       = seq_q + CountW'(1);
        cursor_d    = (cursor_q == SlotW'(LOG_DEPTH - 1)) ? '0 : cursor_q + SlotW'(1);
        if (fill_q < FillW'(LOG_DEPTH)) begin
          fill_d = fill_q + FillW'(1);
        end
        if (expired || alert) begin
          wstart_d = now_q;
        end
        wsum_d   = alert ? '0 : sum;
        alerts_d = alert ? alerts_q + CountW'(1) : alerts_q;
      end
      trwm_pkg::ACT_CLEAR: begin
        transfers_d = '0;
        bytes_d     = '0;
        alerts_d    = '0;
        seq_d       = '0;
        cursor_d    = '0;
        fill_d      = '0;
        wstart_d    = now_q;
        wsum_d      = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      transfers_q <= '0;
      bytes_q     <= '0;
      alerts_q    <= '0;
      seq_q       <= '0;
      wstart_q    <= '0;
      wsum_q      <= '0;
      cursor_q    <= '0;
      fill_q      <= '0;
    end else if (take_o) begin
      now_q       <= now_d;
      transfers_q <= transfers_d;
      bytes_q     <= bytes_d;
      alerts_q    <= alerts_d;
      seq_q       <= seq_d;
      wstart_q    <= wstart_d;
      wsum_q      <= wsum_d;
      cursor_q    <= cursor_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o && is_record) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && is_record) begin
      event_id_o        <= seq_d;
      slot_index_o      <= cursor_q;
      fill_count_o      <= fill_d;
      event_time_o      <= now_q;
      logged_device_o   <= item_i.device_tag;
      alert_o           <= alert;
      window_sum_o      <= sum;
      transfers_total_o <= transfers_d;
      bytes_total_o     <= bytes_d;
      alerts_total_o    <= alerts_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/transfer_rate_window_monitor.sv */
// Top level of the transfer rate window monitor.
// Depends on trwm_pkg, trwm_cfg_regs, trwm_in_reg and trwm_core.
//
//   channel   direction  handshake               payload
//   input     in         in_valid_i / in_stall_o action_i, byte_count_i, device_tag_i
//   result    out        out_valid_o/out_stall_i event_id_o ... alerts_total_o
//   config    in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// A word passes through the input register and its result then through the result register;
// one word is taken per cycle while no stalled result holds back a following record.
// The window sum feeds back through the core's state registers, which sets that rate.
// Ticks and clears give no result word; a record gives exactly one.
// A stalled result only holds back a following record; reset needs no clearing pass.
module transfer_rate_window_monitor #(
  parameter  int unsigned LOG_DEPTH = trwm_pkg::LOG_DEPTH_DEFAULT,
  localparam int unsigned SlotW     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1,
  localparam int unsigned FillW     = $clog2(LOG_DEPTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [trwm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [trwm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [trwm_pkg::ACTION_W-1:0]      action_i,
  input  logic [trwm_pkg::BYTES_W-1:0]       byte_count_i,
  input  logic [trwm_pkg::TAG_W-1:0]         device_tag_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [trwm_pkg::COUNT_W-1:0]       event_id_o,
  output logic [SlotW-1:0]                   slot_index_o,
  output logic [FillW-1:0]                   fill_count_o,
  output logic [trwm_pkg::TICKS_W-1:0]       event_time_o,
  output logic [trwm_pkg::TAG_W-1:0]         logged_device_o,
  output logic                               alert_o,
  output logic [trwm_pkg::SUM_W-1:0]         window_sum_o,
  output logic [trwm_pkg::COUNT_W-1:0]       transfers_total_o,
  output logic [trwm_pkg::COUNT_W-1:0]       bytes_total_o,
  output logic [trwm_pkg::COUNT_W-1:0]       alerts_total_o
);

  trwm_pkg::cfg_t  cfg;
  trwm_pkg::item_t item_in;
  trwm_pkg::item_t item;
  logic            item_valid;
  logic            take;

  assign item_in.action     = action_i;
  assign item_in.byte_count = byte_count_i;
  assign item_in.device_tag = device_tag_i;

  trwm_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  trwm_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (item_in),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  trwm_core #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .item_valid_i      (item_valid),
    .item_i            (item),
    .take_o            (take),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_id_o        (event_id_o),
    .slot_index_o      (slot_index_o),
    .fill_count_o      (fill_count_o),
    .event_time_o      (event_time_o),
    .logged_device_o   (logged_device_o),
    .alert_o           (alert_o),
    .window_sum_o      (window_sum_o),
    .transfers_total_o (transfers_total_o),
    .bytes_total_o     (bytes_total_o),
    .alerts_total_o    (alerts_total_o)
  );

  // The input side only backs up behind a result word that is itself stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result word");

  // The fill count saturates at the ring depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_count_o <= FillW'(LOG_DEPTH)))
    else $error("fill count beyond ring depth");

  // Sequence ids and the transfer count restart and advance together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_id_o == transfers_total_o))
    else $error("event id and transfer count disagree");

  // An alert means the reported window sum reached a nonzero threshold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alert_o) |->
      ((cfg.threshold_mib != '0) &&
       (window_sum_o >= trwm_pkg::SUM_W'({cfg.threshold_mib,
                                          {trwm_pkg::MIB_SHIFT{1'b0}}}))))
    else $error("alert without the threshold reached");

endmodule

/* bench/transfer_rate_window_monitor_test.sv */
// Self-checking bench for transfer_rate_window_monitor: random and directed tick, record
// and clear words, scored against an in-bench model of the counters and alert window.
// Depends on trwm_pkg and the RTL of the block; nothing else.
module transfer_rate_window_monitor_test;

  localparam int unsigned LogDepth = trwm_pkg::LOG_DEPTH_DEFAULT;
  localparam int unsigned SlotW = $clog2(LogDepth);
  localparam int unsigned FillW = $clog2(LogDepth + 1);
  localparam logic [trwm_pkg::ACTION_W-1:0] ActUnused = 2'd3;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned PhaseWords = 220;

  typedef struct {
    logic [trwm_pkg::COUNT_W-1:0]  event_id;
    logic [SlotW-1:0]              slot_index;
    logic [FillW-1:0]              fill_count;
    logic [trwm_pkg::TICKS_W-1:0]  event_time;
    logic [trwm_pkg::TAG_W-1:0]    logged_device;
    logic                          alert;
    logic [trwm_pkg::SUM_W-1:0]    window_sum;
    logic [trwm_pkg::COUNT_W-1:0]  transfers_total;
    logic [trwm_pkg::COUNT_W-1:0]  bytes_total;
    logic [trwm_pkg::COUNT_W-1:0]  alerts_total;
  } monitor_event_t;

  class window_scoreboard;
    logic [trwm_pkg::THRESH_W-1:0] threshold_mib = '0;
    logic [trwm_pkg::TICKS_W-1:0]  window_ticks = trwm_pkg::WINDOW_TICKS_RESET;
    logic [trwm_pkg::TICKS_W-1:0]  now_ticks = '0;
    logic [trwm_pkg::COUNT_W-1:0]  transfers = '0;
    logic [trwm_pkg::COUNT_W-1:0]  bytes_seen = '0;
    logic [trwm_pkg::COUNT_W-1:0]  alerts = '0;
    logic [trwm_pkg::COUNT_W-1:0]  sequence_id = '0;
    logic [trwm_pkg::TICKS_W-1:0]  window_start = '0;
    logic [trwm_pkg::SUM_W-1:0]    sum_in_window = '0;
    logic [SlotW-1:0]              cursor = '0;
    logic [FillW-1:0]              fill = '0;
    monitor_event_t                expected_events[$];
    int unsigned                   errors = 0;

    function void set_reg(trwm_pkg::cfg_idx_e idx, logic [trwm_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        trwm_pkg::CFG_THRESHOLD: threshold_mib = value[trwm_pkg::THRESH_W-1:0];
        trwm_pkg::CFG_WINDOW: window_ticks = value;
        default: ;
      endcase
    endfunction

    // Advances the model by one accepted word; a record queues the event it must produce.
    function void apply_word(logic [trwm_pkg::ACTION_W-1:0] act,
                             logic [trwm_pkg::BYTES_W-1:0] nbytes,
                             logic [trwm_pkg::TAG_W-1:0] tag);
      logic [trwm_pkg::TICKS_W-1:0] left;
      logic [trwm_pkg::SUM_W:0]     wide_sum;
      logic [trwm_pkg::SUM_W-1:0]   limit;
      monitor_event_t               ev;
      case (act)
        trwm_pkg::ACT_TICK: now_ticks = now_ticks + 1'b1;
        trwm_pkg::ACT_CLEAR: begin
          transfers = '0;
          bytes_seen = '0;
          alerts = '0;
          sequence_id = '0;
          cursor = '0;
          fill = '0;
          window_start = now_ticks;
          sum_in_window = '0;
        end
        trwm_pkg::ACT_RECORD: begin
          transfers = transfers + 1'b1;
          bytes_seen = bytes_seen + nbytes;
          sequence_id = sequence_id + 1'b1;
          ev.slot_index = cursor;
          cursor = (cursor == SlotW'(LogDepth - 1)) ? '0 : cursor + 1'b1;
          if (fill < FillW'(LogDepth)) begin
            fill = fill + 1'b1;
          end
          // The window has run out once the remaining time goes negative.
          left = window_start + window_ticks - now_ticks;
          if (left[trwm_pkg::TICKS_W-1]) begin
            window_start = now_ticks;
            sum_in_window = '0;
          end
          wide_sum = {1'b0, sum_in_window} + nbytes;
          sum_in_window = wide_sum[trwm_pkg::SUM_W] ? '1 : wide_sum[trwm_pkg::SUM_W-1:0];
          ev.window_sum = sum_in_window;
          limit = trwm_pkg::SUM_W'(threshold_mib) << trwm_pkg::MIB_SHIFT;
          ev.alert = (limit != '0) && (sum_in_window >= limit);
          if (ev.alert) begin
            alerts = alerts + 1'b1;
            window_start = now_ticks;
            sum_in_window = '0;
          end
          ev.event_id = sequence_id;
          ev.fill_count = fill;
          ev.event_time = now_ticks;
          ev.logged_device = tag;
          ev.transfers_total = transfers;
          ev.bytes_total = bytes_seen;
          ev.alerts_total = alerts;
          expected_events.push_back(ev);
        end
        default: ;
      endcase
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_event(monitor_event_t got);
      monitor_event_t want;
      if (expected_events.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
        return;
      end
      want = expected_events.pop_front();
      compare("event_id", want.event_id, got.event_id);
      compare("slot_index", 64'(want.slot_index), 64'(got.slot_index));
      compare("fill_count", 64'(want.fill_count), 64'(got.fill_count));
      compare("event_time", 64'(want.event_time), 64'(got.event_time));
      compare("logged_device", 64'(want.logged_device), 64'(got.logged_device));
      compare("alert", 64'(want.alert), 64'(got.alert));
      compare("window_sum", 64'(want.window_sum), 64'(got.window_sum));
      compare("transfers_total", want.transfers_total, got.transfers_total);
      compare("bytes_total", want.bytes_total, got.bytes_total);
      compare("alerts_total", want.alerts_total, got.alerts_total);
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [trwm_pkg::CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [trwm_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic [trwm_pkg::ACTION_W-1:0]    action_i = '0;
  logic [trwm_pkg::BYTES_W-1:0]     byte_count_i = '0;
  logic [trwm_pkg::TAG_W-1:0]       device_tag_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [trwm_pkg::COUNT_W-1:0]     event_id_o;
  logic [SlotW-1:0]                 slot_index_o;
  logic [FillW-1:0]                 fill_count_o;
  logic [trwm_pkg::TICKS_W-1:0]     event_time_o;
  logic [trwm_pkg::TAG_W-1:0]       logged_device_o;
  logic                             alert_o;
  logic [trwm_pkg::SUM_W-1:0]       window_sum_o;
  logic [trwm_pkg::COUNT_W-1:0]     transfers_total_o;
  logic [trwm_pkg::COUNT_W-1:0]     bytes_total_o;
  logic [trwm_pkg::COUNT_W-1:0]     alerts_total_o;

  window_scoreboard sb = new();
  monitor_event_t   seen_event;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      idle_cycles = 0;

  transfer_rate_window_monitor uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .byte_count_i,
    .device_tag_i,
    .out_valid_o,
    .out_stall_i,
    .event_id_o,
    .slot_index_o,
    .fill_count_o,
    .event_time_o,
    .logged_device_o,
    .alert_o,
    .window_sum_o,
    .transfers_total_o,
    .bytes_total_o,
    .alerts_total_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.apply_word(action_i, byte_count_i, device_tag_i);
      end
      if (out_valid_o && !out_stall_i) begin
        seen_event.event_id = event_id_o;
        seen_event.slot_index = slot_index_o;
        seen_event.fill_count = fill_count_o;
        seen_event.event_time = event_time_o;
        seen_event.logged_device = logged_device_o;
        seen_event.alert = alert_o;
        seen_event.window_sum = window_sum_o;
        seen_event.transfers_total = transfers_total_o;
        seen_event.bytes_total = bytes_total_o;
        seen_event.alerts_total = alerts_total_o;
        sb.check_event(seen_event);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(trwm_pkg::cfg_idx_e idx, logic [trwm_pkg::CFG_DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  // Presents one word and returns at the edge that accepts it, valid still high.
  task automatic send_word(logic [trwm_pkg::ACTION_W-1:0] act,
                           logic [trwm_pkg::BYTES_W-1:0] nbytes,
                           logic [trwm_pkg::TAG_W-1:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    byte_count_i <= nbytes;
    device_tag_i <= tag;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  // Ticks and clears give no result, so the task waits on past the last pending result to let them pass.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_traffic(int unsigned count, int unsigned clear_pct);
    logic [trwm_pkg::ACTION_W-1:0] act;
    logic [trwm_pkg::BYTES_W-1:0]  nbytes;
    int unsigned                   roll;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < clear_pct) begin
        act = trwm_pkg::ACT_CLEAR;
      end else if (roll < clear_pct + 2) begin
        act = ActUnused;
      end else if (roll < clear_pct + 32) begin
        act = trwm_pkg::ACT_TICK;
      end else begin
        act = trwm_pkg::ACT_RECORD;
      end
      case ($urandom_range(3))
        0: nbytes = '1;
        1: nbytes = $urandom;
        2: nbytes = $urandom_range(0, 4095);
        default: nbytes = {12'($urandom), 20'h0} - 32'($urandom_range(0, 1));
      endcase
      send_word(act, nbytes, 16'($urandom));
    end
  endtask

  initial begin
    logic [trwm_pkg::CFG_DATA_W-1:0] thr;
    logic [trwm_pkg::CFG_DATA_W-1:0] win;
    int unsigned                     clear_pct;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: alerts off, so a full-size write only accumulates.
    send_word(trwm_pkg::ACT_RECORD, '1, '1);
    send_word(trwm_pkg::ACT_RECORD, '0, '0);
    send_word(trwm_pkg::ACT_TICK, '0, '0);
    send_word(ActUnused, '1, '1);
    send_word(trwm_pkg::ACT_CLEAR, '0, '0);
    send_word(trwm_pkg::ACT_RECORD, 32'd1, 16'h1234);
    drain();

    // One MiB threshold: just below, exactly on, and far above the limit.
    write_reg(trwm_pkg::CFG_THRESHOLD, 32'd1);
    write_reg(trwm_pkg::CFG_WINDOW, 32'd3);
    send_word(trwm_pkg::ACT_RECORD, 32'h000F_FFFF, 16'hA5A5);
    send_word(trwm_pkg::ACT_RECORD, 32'd1, 16'h5A5A);
    send_word(trwm_pkg::ACT_RECORD, '1, '1);
    repeat (4) send_word(trwm_pkg::ACT_TICK, '0, '0);
    send_word(trwm_pkg::ACT_RECORD, 32'd5, 16'h0001);
    send_word(trwm_pkg::ACT_CLEAR, '1, '1);
    send_word(trwm_pkg::ACT_RECORD, 32'h000F_FFFF, 16'h8000);
    drain();

    // A zero-length window expires as soon as time moves on.
    write_reg(trwm_pkg::CFG_THRESHOLD, 32'd65535);
    write_reg(trwm_pkg::CFG_WINDOW, 32'd0);
    send_word(trwm_pkg::ACT_RECORD, '1, 16'h00FF);
    send_word(trwm_pkg::ACT_TICK, '0, '0);
    send_word(trwm_pkg::ACT_RECORD, 32'd1, 16'hFF00);
    send_word(trwm_pkg::ACT_RECORD, 32'd2, 16'h0F0F);
    drain();

    // An all-ones window reads as expired while under half the time range has elapsed.
    write_reg(trwm_pkg::CFG_WINDOW, '1);
    send_word(trwm_pkg::ACT_RECORD, 32'd3, 16'hF0F0);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      clear_pct = 3;
      case (p)
        0: begin thr = 32'd1; win = 32'd8; end
        1: begin thr = 32'd65535; win = 32'h7FFF_FFFF; clear_pct = 0; end
        2: begin thr = $urandom_range(1, 4096); win = 32'd0; end
        // Alerts off with a long window and no clears lets the sum saturate.
        3: begin thr = 32'd0; win = 32'h7FFF_FFFF; clear_pct = 0; end
        4: begin thr = $urandom_range(1, 65535); win = '1; end
        5: begin thr = $urandom_range(1, 2048); win = $urandom_range(1, 64); end
        6: begin thr = 32'd4096; win = 32'd20; clear_pct = 5; end
        default: begin thr = $urandom_range(1, 512); win = $urandom_range(1, 4); end
      endcase
      write_reg(trwm_pkg::CFG_THRESHOLD, thr);
      write_reg(trwm_pkg::CFG_WINDOW, win);
      run_traffic(PhaseWords, clear_pct);
      drain();
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

/* transfer_rate_window_monitor.f */
rtl/trwm_pkg.sv
rtl/trwm_cfg_regs.sv
rtl/trwm_in_reg.sv
rtl/trwm_core.sv
rtl/transfer_rate_window_monitor.sv
bench/transfer_rate_window_monitor_test.sv
